// ----- hw/rtl/ctt_pkg.sv -----
// contact track table package: table size, entry record, controller states
// no dependencies; imported by every module of the block
`default_nettype none
package ctt_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned LiveW = $clog2(TableEntries + 1);
  localparam int unsigned IdentBytes = 20;
  localparam logic [31:0] ExpireLimitReset = 32'd30000;

  typedef struct packed {
    logic        used;
    logic [47:0] addr;
    logic [63:0] ident_head;
    logic [63:0] ident_middle;
    logic [31:0] ident_tail;
    logic [31:0] last_seen;
    logic [31:0] first_seen;
    logic [31:0] messages;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } ctt_state_e;
endpackage
`default_nettype wire

// ----- hw/rtl/ctt_cell.sv -----
// one cell of the rotating track ring: holds one entry, takes its neighbour's on shift
// depends on ctt_pkg
`default_nettype none
module ctt_cell (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            shift_i,
  input  ctt_pkg::entry_t entry_i,
  output ctt_pkg::entry_t entry_o
);
  import ctt_pkg::*;

  logic   used_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= entry_i.used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o      = data_q;
    entry_o.used = used_q;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/contact_track_table.sv -----
// contact track table top level: ring of entry cells plus scan and update control
// depends on ctt_pkg and ctt_cell
// an update beat runs a scan lap then a write lap; an expire beat runs the scan lap only
// one beat at a time: busy rises after acceptance and stays high until the result strobe
// the ring rotates one cell a cycle while scanning or writing; one lap brings every entry past the head once
// reset clears used flags, the controller and sets the expire limit to 30000 ms
// results last one cycle on result_valid_o; the receiver cannot stall
`default_nettype none
module contact_track_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  input  wire         mode_i,
  input  wire  [47:0] hw_address_i,
  input  wire  [63:0] ident_head_i,
  input  wire  [63:0] ident_middle_i,
  input  wire  [31:0] ident_tail_i,
  input  wire  [31:0] now_ms_i,
  output logic        result_valid_o,
  output logic [ctt_pkg::IdxW-1:0]  slot_o,
  output logic        created_o,
  output logic [31:0] message_count_o,
  output logic [31:0] first_seen_ms_o,
  output logic [ctt_pkg::LiveW-1:0] live_count_o
);
  import ctt_pkg::*;

  // the ring
  entry_t ring [TableEntries];
  entry_t head, feedback;
  logic   shift;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    entry_t cell_in;
    if (g == TableEntries - 1) begin : g_last
      assign cell_in = feedback;
    end else begin : g_mid
      assign cell_in = ring[g+1];
    end
    ctt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (ring[g])
    );
  end

  assign head = ring[0];

  // expire limit register
  logic [31:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ExpireLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // identity canonicalisation: bytes after the first zero are forced to zero
  logic [8*IdentBytes-1:0] id_raw, id_canon;
  assign id_raw = {ident_tail_i, ident_middle_i, ident_head_i};
  always_comb begin
    logic ended;
    ended    = 1'b0;
    id_canon = id_raw;
    for (int k = 0; k < IdentBytes; k++) begin
      if (ended) begin
        id_canon[8*k +: 8] = 8'h00;
      end else if (id_raw[8*k +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
  end

  // captured beat
  logic        mode_q;
  logic [47:0] addr_q;
  logic [63:0] ih_q, im_q;
  logic [31:0] it_q, now_q;
  logic        has_id;
  assign has_id = (ih_q[7:0] != 8'h00);

  ctt_state_e state_q, state_d;
  logic [IdxW-1:0]  cnt_q;
  logic [LiveW-1:0] live_q;
  logic             last_step;
  logic             accept;

  assign accept    = start && (state_q == ST_IDLE);
  assign last_step = (cnt_q == IdxW'(TableEntries - 1));
  assign busy      = (state_q != ST_IDLE);

  // scan findings
  logic            id_hit_q, addr_hit_q, addr_empty_q, free_hit_q, old_hit_q;
  logic [IdxW-1:0] id_idx_q, addr_idx_q, free_idx_q, old_idx_q;
  logic [31:0]     old_seen_q;

  // slot choice, read during the write lap when the findings hold still
  logic [IdxW-1:0] sel_idx;
  logic            sel_new;
  always_comb begin
    sel_new = 1'b0;
    if (id_hit_q) begin
      sel_idx = id_idx_q;
    end else if (addr_hit_q && (!has_id || addr_empty_q)) begin
      sel_idx = addr_idx_q;
    end else begin
      sel_new = 1'b1;
      sel_idx = free_hit_q ? free_idx_q : (old_hit_q ? old_idx_q : '0);
    end
  end

  // head entry after an update
  entry_t upd;
  always_comb begin
    upd = head;
    if (sel_new) begin
      upd.used         = 1'b1;
      upd.ident_head   = '0;
      upd.ident_middle = '0;
      upd.ident_tail   = '0;
      upd.messages     = 32'd1;
      upd.first_seen   = now_q;
    end else begin
      upd.messages = head.messages + 32'd1;
    end
    upd.addr = addr_q;
    if (has_id) begin
      upd.ident_head   = ih_q;
      upd.ident_middle = im_q;
      upd.ident_tail   = it_q;
    end
    upd.last_seen = now_q;
  end

  logic aged;
  assign aged = ((now_q - head.last_seen) > limit_q);

  always_comb begin
    state_d  = state_q;
    shift    = 1'b0;
    feedback = head;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (mode_q && head.used && aged) begin
          feedback.used = 1'b0;
        end
        if (last_step) begin
          state_d = mode_q ? ST_IDLE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        shift = 1'b1;
        if (cnt_q == sel_idx) begin
          feedback = upd;
        end
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // lap counter, live count and result strobe
  logic [LiveW-1:0] live_next;
  assign live_next = live_q + LiveW'(feedback.used);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      live_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (accept) begin
        cnt_q  <= '0;
        live_q <= '0;
      end else if (shift) begin
        cnt_q <= last_step ? '0 : cnt_q + IdxW'(1);
        if (state_q == ST_WRITE || mode_q) begin
          live_q <= live_next;
        end
        if (last_step && (state_q == ST_WRITE || mode_q)) begin
          result_valid_o <= 1'b1;
        end
      end
    end
  end

  // beat capture, scan bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= mode_i;
      addr_q     <= hw_address_i;
      ih_q       <= id_canon[63:0];
      im_q       <= id_canon[127:64];
      it_q       <= id_canon[159:128];
      now_q      <= now_ms_i;
      id_hit_q   <= 1'b0;
      addr_hit_q <= 1'b0;
      free_hit_q <= 1'b0;
      old_hit_q  <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      if (!head.used) begin
        if (!free_hit_q) begin
          free_hit_q <= 1'b1;
          free_idx_q <= cnt_q;
        end
      end else begin
        if (has_id && head.ident_head == ih_q && head.ident_middle == im_q
            && head.ident_tail == it_q) begin
          id_hit_q <= 1'b1;
          id_idx_q <= cnt_q;
        end
        if (head.addr == addr_q) begin
          addr_hit_q   <= 1'b1;
          addr_idx_q   <= cnt_q;
          addr_empty_q <= (head.ident_head[7:0] == 8'h00);
        end
        if (!old_hit_q || head.last_seen < old_seen_q) begin
          old_hit_q  <= 1'b1;
          old_idx_q  <= cnt_q;
          old_seen_q <= head.last_seen;
        end
      end
      if (last_step) begin
        if (mode_q) begin
          slot_o          <= '0;
          created_o       <= 1'b0;
          message_count_o <= '0;
          first_seen_ms_o <= '0;
          live_count_o    <= live_next;
        end
      end
    end else if (state_q == ST_WRITE) begin
      if (cnt_q == sel_idx) begin
        slot_o          <= sel_idx;
        created_o       <= sel_new;
        message_count_o <= upd.messages;
        first_seen_ms_o <= upd.first_seen;
      end
      if (last_step) begin
        live_count_o <= live_next;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ctt_checker.sv -----
// port-level checks for the contact track table
// depends on ctt_pkg; bound to contact_track_table
`default_nettype none
module ctt_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start,
  input wire busy,
  input wire result_valid_o,
  input wire created_o,
  input wire [31:0] message_count_o,
  input wire [ctt_pkg::LiveW-1:0] live_count_o
);
  import ctt_pkg::*;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("no busy after accepted beat");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("busy during result");
  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> live_count_o <= LiveW'(TableEntries)) else $error("live count too big");
  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && created_o |-> message_count_o == 32'd1) else $error("new track count");
endmodule

bind contact_track_table ctt_checker u_ctt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .created_o       (created_o),
  .message_count_o (message_count_o),
  .live_count_o    (live_count_o)
);
`default_nettype wire
